/* hw/rtl/interval_running_statistics_assert.svh */
// Assertion macros used by the checker file.
`ifndef INTERVAL_RUNNING_STATISTICS_ASSERT_SVH
`define INTERVAL_RUNNING_STATISTICS_ASSERT_SVH

// Implication checked on every clock edge outside reset.
`define IRS_ASSERT_IMPL(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);

// Condition in the cycle after a trigger.
`define IRS_ASSERT_NEXT(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

/* hw/rtl/irs_pkg.sv */
// ----------------------------------------------------------------------------
// irs_pkg
// Widths, status codes and histogram edges of the interval statistics block.
// ----------------------------------------------------------------------------
package irs_pkg;
    localparam int COUNT_BITS_DEF = 18;
    localparam int HIST_BINS_DEF  = 10;
    localparam int IN_W    = 23;
    localparam int SUM_W   = 41;
    localparam int SQ_W    = 64;
    localparam int DEV_W   = 22;
    localparam logic [IN_W-1:0] INTERVAL_LIMIT = 23'd6000000;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_RANGE     = 2'd1,
        ST_SATURATED = 2'd2
    } status_t;

    // Upper bound of bin i, in 10 us units; the last bin is open.
    function automatic logic [IN_W-1:0] bin_upper(input logic [3:0] i);
        logic [IN_W-1:0] r;
        unique case (i)
            4'd0: r = 23'd75;
            4'd1: r = 23'd150;
            4'd2: r = 23'd250;
            4'd3: r = 23'd350;
            4'd4: r = 23'd450;
            4'd5: r = 23'd650;
            4'd6: r = 23'd900;
            4'd7: r = 23'd1250;
            4'd8: r = 23'd2000;
            default: r = '1;
        endcase
        return r;
    endfunction
endpackage

/* hw/rtl/irs_divider.sv */
// ----------------------------------------------------------------------------
// irs_divider
// Bit-serial restoring divider: one quotient bit per cycle.
// ----------------------------------------------------------------------------
module irs_divider
    import irs_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [SQ_W-1:0]       dividend,
    input  logic [COUNT_BITS-1:0] divisor,
    output logic                  done,
    output logic [SQ_W-1:0]       quotient
);
    localparam int CNT_W = $clog2(SQ_W + 1);

    logic [SQ_W-1:0]       quo_reg;
    logic [COUNT_BITS:0]   rem_reg;
    logic [COUNT_BITS-1:0] div_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic                  busy_reg;
    logic                  done_reg;
    logic [COUNT_BITS+1:0] trial;

    // Shift in the next dividend bit and try one subtraction.
    assign trial = {rem_reg, quo_reg[SQ_W-1]} - {2'b00, div_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            // The quotient is complete in the cycle after the last bit.
            done_reg <= busy_reg && (cnt_reg == CNT_W'(1));
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(SQ_W);
                quo_reg  <= dividend;
                rem_reg  <= '0;
                div_reg  <= divisor;
            end
            else if (busy_reg)
            begin
                if (!trial[COUNT_BITS+1])
                    rem_reg <= trial[COUNT_BITS:0];
                else
                    rem_reg <= {rem_reg[COUNT_BITS-1:0], quo_reg[SQ_W-1]};
                quo_reg <= {quo_reg[SQ_W-2:0], ~trial[COUNT_BITS+1]};
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                    busy_reg <= 1'b0;
            end
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;
endmodule

/* hw/rtl/interval_running_statistics.sv */
// ----------------------------------------------------------------------------
// interval_running_statistics
// Running count, mean, deviation, extremes and histogram of poll intervals.
// ----------------------------------------------------------------------------
// One item at a time. An accepted interval passes through these steps before its
// result is offered: the bit-serial square, the histogram bin search, two passes
// of the shared serial divider (mean, then mean square), the mean-squared
// product, the bit-pair square root and the mode scan. A rejected interval
// skips the square and the bin search. The result sits in an output register;
// the next interval is taken once the result has been transferred.
module interval_running_statistics
    import irs_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEF,
    parameter int HIST_BINS  = HIST_BINS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [IN_W-1:0]       interval,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [1:0]            status,
    output logic [COUNT_BITS-1:0] sample_count,
    output logic [IN_W-1:0]       least,
    output logic [IN_W-1:0]       greatest,
    output logic [IN_W-1:0]       mean,
    output logic [DEV_W-1:0]      deviation,
    output logic [3:0]            mode_bin,
    output logic                  mode_valid
);
    typedef enum logic [3:0] {
        S_IDLE, S_SQUARE, S_BIN, S_DIV1, S_DIV1W, S_DIV2, S_DIV2W,
        S_MSQ, S_SQRT, S_MODE, S_OUT
    } state_t;

    localparam int BIN_IDX_W = $clog2(HIST_BINS);
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    state_t                state_reg;
    logic [IN_W-1:0]       x_reg;
    logic [COUNT_BITS-1:0] count_reg;
    logic [SUM_W-1:0]      sum_reg;
    logic [SQ_W-1:0]       sumsq_reg;
    logic [IN_W-1:0]       min_reg, max_reg;
    logic [COUNT_BITS-1:0] bins_reg [HIST_BINS];
    logic [5:0]            step_reg;
    logic [SQ_W-1:0]       acc_reg;
    logic [SQ_W-1:0]       mplier_reg;
    logic [IN_W-1:0]       mean_reg;
    logic [SQ_W-1:0]       msq_reg;
    logic [SQ_W-1:0]       rem_reg;
    logic [31:0]           root_reg;
    logic [BIN_IDX_W-1:0]  idx_reg;
    logic [COUNT_BITS-1:0] best_reg;
    logic [3:0]            mode_reg;
    logic [1:0]            status_reg;
    logic                  out_valid_reg;

    logic                  div_start;
    logic [SQ_W-1:0]       div_dividend;
    logic                  div_done;
    logic [SQ_W-1:0]       div_quo;
    logic [SQ_W+1:0]       sq_trial;
    logic [SQ_W-1:0]       rem_shift;

    irs_divider #(.COUNT_BITS(COUNT_BITS)) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (count_reg),
        .done     (div_done),
        .quotient (div_quo)
    );

    assign div_start    = (state_reg == S_DIV1) || (state_reg == S_DIV2);
    assign div_dividend = (state_reg == S_DIV1) ? SQ_W'(sum_reg) : sumsq_reg;

    // Square root, one bit pair per step: acc_reg holds the radicand.
    assign rem_shift = {rem_reg[SQ_W-3:0], acc_reg[SQ_W-1:SQ_W-2]};
    assign sq_trial  = {2'b00, rem_shift} - {{(SQ_W-32){1'b0}}, root_reg, 2'b01};

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            count_reg     <= '0;
            sum_reg       <= '0;
            sumsq_reg     <= '0;
            min_reg       <= '0;
            max_reg       <= '0;
            for (int i = 0; i < HIST_BINS; i++)
                bins_reg[i] <= '0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        x_reg <= interval;
                        if (interval >= INTERVAL_LIMIT)
                        begin
                            status_reg <= ST_RANGE;
                            state_reg  <= S_DIV1;
                        end
                        else if (count_reg == COUNT_MAX)
                        begin
                            status_reg <= ST_SATURATED;
                            state_reg  <= S_DIV1;
                        end
                        else
                        begin
                            status_reg <= ST_OK;
                            acc_reg    <= '0;
                            mplier_reg <= SQ_W'(interval);
                            step_reg   <= '0;
                            state_reg  <= S_SQUARE;
                        end
                    end
                end
                S_SQUARE:
                begin
                    // Shift-and-add x*x, one multiplier bit per cycle.
                    if (x_reg[step_reg[4:0]])
                        acc_reg <= acc_reg + (mplier_reg << step_reg);
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == 6'(IN_W - 1))
                    begin
                        idx_reg   <= '0;
                        state_reg <= S_BIN;
                    end
                end
                S_BIN:
                begin
                    if (x_reg < bin_upper(4'(idx_reg))
                        || idx_reg == BIN_IDX_W'(HIST_BINS - 1))
                    begin
                        bins_reg[idx_reg] <= bins_reg[idx_reg] + 1'b1;
                        count_reg <= count_reg + 1'b1;
                        sum_reg   <= sum_reg + SUM_W'(x_reg);
                        sumsq_reg <= sumsq_reg + acc_reg;
                        if (count_reg == '0 || x_reg < min_reg)
                            min_reg <= x_reg;
                        if (count_reg == '0 || x_reg > max_reg)
                            max_reg <= x_reg;
                        state_reg <= S_DIV1;
                    end
                    else
                        idx_reg <= idx_reg + 1'b1;
                end
                S_DIV1:
                    state_reg <= S_DIV1W;
                S_DIV1W:
                begin
                    if (div_done)
                    begin
                        mean_reg  <= (count_reg == '0) ? '0 : div_quo[IN_W-1:0];
                        state_reg <= S_DIV2;
                    end
                end
                S_DIV2:
                    state_reg <= S_DIV2W;
                S_DIV2W:
                begin
                    if (div_done)
                    begin
                        msq_reg    <= div_quo;
                        acc_reg    <= '0;
                        mplier_reg <= SQ_W'(mean_reg);
                        step_reg   <= '0;
                        state_reg  <= S_MSQ;
                    end
                end
                S_MSQ:
                begin
                    // mean*mean, serial; then load the radicand.
                    if (step_reg == 6'(IN_W))
                    begin
                        if (count_reg >= COUNT_BITS'(2) && msq_reg > acc_reg)
                            acc_reg <= msq_reg - acc_reg;
                        else
                            acc_reg <= '0;
                        rem_reg   <= '0;
                        root_reg  <= '0;
                        step_reg  <= '0;
                        state_reg <= S_SQRT;
                    end
                    else
                    begin
                        if (mean_reg[step_reg[4:0]])
                            acc_reg <= acc_reg + (mplier_reg << step_reg);
                        step_reg <= step_reg + 1'b1;
                    end
                end
                S_SQRT:
                begin
                    acc_reg <= {acc_reg[SQ_W-3:0], 2'b00};
                    if (!sq_trial[SQ_W+1])
                    begin
                        rem_reg  <= sq_trial[SQ_W-1:0];
                        root_reg <= {root_reg[30:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg  <= rem_shift;
                        root_reg <= {root_reg[30:0], 1'b0};
                    end
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == 6'd31)
                    begin
                        idx_reg   <= '0;
                        best_reg  <= '0;
                        mode_reg  <= '0;
                        state_reg <= S_MODE;
                    end
                end
                S_MODE:
                begin
                    if (bins_reg[idx_reg] > best_reg)
                    begin
                        best_reg <= bins_reg[idx_reg];
                        mode_reg <= 4'(idx_reg);
                    end
                    idx_reg <= idx_reg + 1'b1;
                    if (idx_reg == BIN_IDX_W'(HIST_BINS - 1))
                    begin
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    if (out_ready)
                    begin
                        out_valid_reg <= 1'b0;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    assign status       = status_reg;
    assign sample_count = count_reg;
    assign least        = (count_reg == '0) ? '0 : min_reg;
    assign greatest     = (count_reg == '0) ? '0 : max_reg;
    assign mean         = mean_reg;
    assign deviation    = root_reg[DEV_W-1:0];
    assign mode_bin     = mode_reg;
    assign mode_valid   = (best_reg != '0);
endmodule

/* hw/rtl/irs_checker.sv */
// ----------------------------------------------------------------------------
// irs_checker
// Port-level checks of the interval statistics block.
// ----------------------------------------------------------------------------
`include "interval_running_statistics_assert.svh"

module irs_checker
    import irs_pkg::*;
(
    input logic            clk,
    input logic            rst_n,
    input logic            in_valid,
    input logic            in_ready,
    input logic            out_valid,
    input logic            out_ready,
    input logic [1:0]      status,
    input logic [3:0]      mode_bin,
    input logic            mode_valid,
    input logic [IN_W-1:0] least,
    input logic [IN_W-1:0] greatest
)
;
    logic out_stall;
    logic status_known;
    logic extremes_ok;

    assign out_stall    = out_valid && !out_ready;
    assign status_known = (status == ST_OK) || (status == ST_RANGE) || (status == ST_SATURATED);
    assign extremes_ok  = (least <= greatest) && (mode_valid || mode_bin == 4'd0);

    `IRS_ASSERT_IMPL(a_one_side, clk, rst_n, out_valid, !in_ready, "ready while result pending")
    `IRS_ASSERT_NEXT(a_hold, clk, rst_n, out_stall, out_valid && $stable(status), "result lost")
    `IRS_ASSERT_IMPL(a_status, clk, rst_n, out_valid, status_known, "bad status")
    `IRS_ASSERT_IMPL(a_order, clk, rst_n, out_valid, extremes_ok, "bad extremes or mode")
    `IRS_ASSERT_NEXT(a_single, clk, rst_n, in_valid && in_ready, !in_ready, "second input taken")
endmodule

bind interval_running_statistics irs_checker u_irs_checker (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .status(status),
    .mode_bin(mode_bin), .mode_valid(mode_valid), .least(least), .greatest(greatest)
);

/* tb/tb_interval_running_statistics.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_interval_running_statistics
// Drives poll intervals through the statistics block and checks each result
// against a behavioral model of the running count, extremes, mean, deviation
// and histogram mode, under several patterns of idle and stall cycles.
// ----------------------------------------------------------------------------
module tb_interval_running_statistics;
    import irs_pkg::*;

    localparam int CNT_W     = COUNT_BITS_DEF;
    localparam int NBINS     = HIST_BINS_DEF;
    localparam int N_RANDOM  = 1350;
    localparam int IDLE_LIMIT = 20000;
    localparam int HOLD_CYCLES = 2000;

    typedef struct packed {
        logic [1:0]       status;
        logic [CNT_W-1:0] sample_count;
        logic [IN_W-1:0]  least;
        logic [IN_W-1:0]  greatest;
        logic [IN_W-1:0]  mean;
        logic [DEV_W-1:0] deviation;
        logic [3:0]       mode_bin;
        logic             mode_valid;
    } stats_t;

    typedef struct {
        logic [IN_W-1:0] interval;
        bit              fixed;
        stats_t          stats;
    } row_t;

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_ready;
    logic [IN_W-1:0]       interval;
    logic                  out_valid;
    logic                  out_ready;
    logic [1:0]            status;
    logic [CNT_W-1:0]      sample_count;
    logic [IN_W-1:0]       least;
    logic [IN_W-1:0]       greatest;
    logic [IN_W-1:0]       mean;
    logic [DEV_W-1:0]      deviation;
    logic [3:0]            mode_bin;
    logic                  mode_valid;

    // Model state.
    logic [CNT_W-1:0] m_count;
    logic [SUM_W-1:0] m_sum;
    logic [SQ_W-1:0]  m_sumsq;
    logic [IN_W-1:0]  m_min;
    logic [IN_W-1:0]  m_max;
    logic [CNT_W-1:0] m_bins [NBINS];

    stats_t expected_stats [$];
    int     errors;
    int     idle_cycles;
    int     send_idle_pct;
    int     recv_stall_pct;
    bit     recv_hold;

    interval_running_statistics i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .interval     (interval),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .status       (status),
        .sample_count (sample_count),
        .least        (least),
        .greatest     (greatest),
        .mean         (mean),
        .deviation    (deviation),
        .mode_bin     (mode_bin),
        .mode_valid   (mode_valid)
    );

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    function automatic logic [SQ_W-1:0] isqrt(input logic [SQ_W-1:0] v);
        logic [SQ_W-1:0] root;
        logic [SQ_W-1:0] bitv;
        root = '0;
        bitv = 64'd1 << 62;
        while (bitv > v)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (v >= root + bitv)
            begin
                v = v - (root + bitv);
                root = (root >> 1) + bitv;
            end
            else
                root = root >> 1;
            bitv = bitv >> 2;
        end
        return root;
    endfunction

    function automatic int bin_index(input logic [IN_W-1:0] x);
        if (x < 75)   return 0;
        if (x < 150)  return 1;
        if (x < 250)  return 2;
        if (x < 350)  return 3;
        if (x < 450)  return 4;
        if (x < 650)  return 5;
        if (x < 900)  return 6;
        if (x < 1250) return 7;
        if (x < 2000) return 8;
        return 9;
    endfunction

    task automatic clear_model();
        m_count = '0;
        m_sum   = '0;
        m_sumsq = '0;
        m_min   = '0;
        m_max   = '0;
        for (int i = 0; i < NBINS; i++)
            m_bins[i] = '0;
    endtask

    // Applies one interval to the model and returns the statistics after it.
    function automatic stats_t update_stats(input logic [IN_W-1:0] x);
        stats_t           s;
        logic [SQ_W-1:0]  mn;
        logic [SQ_W-1:0]  msq;
        logic [SQ_W-1:0]  dev;
        logic [CNT_W-1:0] best;
        s = '0;
        mn = '0;
        dev = '0;
        best = '0;
        if (x >= INTERVAL_LIMIT)
            s.status = ST_RANGE;
        else if (m_count == {CNT_W{1'b1}})
            s.status = ST_SATURATED;
        else
        begin
            s.status = ST_OK;
            m_count = m_count + 1'b1;
            m_sum   = m_sum + x;
            m_sumsq = m_sumsq + SQ_W'(x) * SQ_W'(x);
            if (m_count == 1)
            begin
                m_min = x;
                m_max = x;
            end
            else
            begin
                if (x < m_min) m_min = x;
                if (x > m_max) m_max = x;
            end
            m_bins[bin_index(x)] = m_bins[bin_index(x)] + 1'b1;
        end
        if (m_count != 0)
            mn = SQ_W'(m_sum) / SQ_W'(m_count);
        if (m_count >= 2)
        begin
            msq = m_sumsq / SQ_W'(m_count);
            if (msq > mn * mn)
                dev = isqrt(msq - mn * mn);
        end
        for (int i = 0; i < NBINS; i++)
            if (m_bins[i] > best)
            begin
                best = m_bins[i];
                s.mode_bin = 4'(i);
            end
        s.sample_count = m_count;
        s.least        = (m_count != 0) ? m_min : '0;
        s.greatest     = (m_count != 0) ? m_max : '0;
        s.mean         = IN_W'(mn);
        s.deviation    = DEV_W'(dev);
        s.mode_valid   = (best != 0);
        return s;
    endfunction

    task automatic report_mismatch(input string field, input longint got, input longint exp);
        errors++;
        $display("mismatch on %s: got %0d, expected %0d", field, got, exp);
    endtask

    // Sends one interval, honoring the sender idle percentage. Valid stays
    // high after the transfer so that back-to-back items need no gap; idle
    // cycles and drain() take it low.
    task automatic send_interval(input logic [IN_W-1:0] x, input bit fixed, input stats_t s);
        stats_t pred;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        interval <= x;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        pred = update_stats(x);
        if (fixed && pred != s)
        begin
            errors++;
            $display("table row for interval %0d disagrees with the model", x);
        end
        expected_stats.push_back(fixed ? s : pred);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (expected_stats.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [IN_W-1:0] random_interval();
        int sel;
        sel = $urandom_range(99);
        if (sel < 70) return IN_W'($urandom_range(2500));
        if (sel < 85) return IN_W'($urandom_range(5999999));
        if (sel < 92) return IN_W'($urandom_range(5999999, 5999990));
        return IN_W'($urandom_range(8388607, 6000000));
    endfunction

    // Receiver side: stalls at random, or holds off completely on request.
    always @(posedge clk)
    begin
        if (rst_n)
            out_ready <= !recv_hold && ($urandom_range(99) >= recv_stall_pct);
    end

    // Result checker.
    always @(posedge clk)
    begin
        stats_t e;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_stats.size() == 0)
                report_mismatch("pending results", 0, 1);
            else
            begin
                e = expected_stats.pop_front();
                if (status != e.status) report_mismatch("status", status, e.status);
                if (sample_count != e.sample_count)
                    report_mismatch("sample_count", sample_count, e.sample_count);
                if (least != e.least) report_mismatch("least", least, e.least);
                if (greatest != e.greatest) report_mismatch("greatest", greatest, e.greatest);
                if (mean != e.mean) report_mismatch("mean", mean, e.mean);
                if (deviation != e.deviation)
                    report_mismatch("deviation", deviation, e.deviation);
                if (mode_bin != e.mode_bin) report_mismatch("mode_bin", mode_bin, e.mode_bin);
                if (mode_valid != e.mode_valid)
                    report_mismatch("mode_valid", mode_valid, e.mode_valid);
            end
        end
    end

    // Watchdog on cycles without any transfer.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else if (rst_n)
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("** interval_running_statistics: FAILED **");
            $finish;
        end
    end

    initial
    begin
        row_t table_rows [$];
        stats_t s;
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        interval       = '0;
        out_ready      = 1'b0;
        errors         = 0;
        idle_cycles    = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        recv_hold      = 1'b0;
        clear_model();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Out of range before any sample: all statistics still zero.
        s = '0;
        s.status = ST_RANGE;
        table_rows.push_back('{23'd6000000, 1'b1, s});
        s.status = ST_RANGE;
        table_rows.push_back('{23'd8388607, 1'b1, s});
        // First sample sets both extremes; zero lands in the lowest bin.
        s = '0;
        s.status = ST_OK;
        s.sample_count = 1;
        s.mode_valid = 1'b1;
        table_rows.push_back('{23'd0, 1'b1, s});
        table_rows.push_back('{23'd5999999, 1'b0, s});
        table_rows.push_back('{23'd6000001, 1'b0, s});
        // Bin edges, on both sides for 75, 150, 1250 and 2000.
        table_rows.push_back('{23'd74, 1'b0, s});
        table_rows.push_back('{23'd75, 1'b0, s});
        table_rows.push_back('{23'd149, 1'b0, s});
        table_rows.push_back('{23'd150, 1'b0, s});
        table_rows.push_back('{23'd250, 1'b0, s});
        table_rows.push_back('{23'd350, 1'b0, s});
        table_rows.push_back('{23'd450, 1'b0, s});
        table_rows.push_back('{23'd650, 1'b0, s});
        table_rows.push_back('{23'd900, 1'b0, s});
        table_rows.push_back('{23'd1249, 1'b0, s});
        table_rows.push_back('{23'd1250, 1'b0, s});
        table_rows.push_back('{23'd1999, 1'b0, s});
        table_rows.push_back('{23'd2000, 1'b0, s});
        table_rows.push_back('{23'd4194304, 1'b0, s});
        table_rows.push_back('{23'd5555555, 1'b0, s});
        table_rows.push_back('{23'd2000, 1'b0, s});

        foreach (table_rows[i])
            send_interval(table_rows[i].interval, table_rows[i].fixed, table_rows[i].stats);

        // Random part in phases of idling.
        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 51; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 51; end
                default: begin send_idle_pct = 16; recv_stall_pct = 16; end
            endcase
            if (ph == 2)
            begin
                fork
                    begin
                        recv_hold = 1'b1;
                        repeat (HOLD_CYCLES) @(posedge clk);
                        recv_hold = 1'b0;
                    end
                join_none
            end
            for (int n = 0; n < N_RANDOM / 4; n++)
                send_interval(random_interval(), 1'b0, s);
            // Sender pauses until every result is back.
            drain();
        end

        send_idle_pct = 0;
        recv_stall_pct = 0;
        repeat (400) @(posedge clk);
        if (errors == 0)
            $display("** interval_running_statistics: PASSED **");
        else
            $display("** interval_running_statistics: FAILED **");
        $finish;
    end
endmodule

/* interval_running_statistics.f */
+incdir+hw/rtl
hw/rtl/irs_pkg.sv
hw/rtl/irs_divider.sv
hw/rtl/interval_running_statistics.sv
hw/rtl/irs_checker.sv
tb/tb_interval_running_statistics.sv
